@@ design/lsrk_pkg.sv @@
package lsrk_pkg;

	localparam int OPW = 65;
	localparam int MAG_W = 64;
	localparam int OUT_W = 47;
	localparam int INDEX_OUT_W = 32;
	localparam int CFG_DATA_W = 47;
	localparam int CFG_IDX_W = 3;
	localparam int PC_W = 7;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t CFG_GROWTH_RATE = 3'd0;
	localparam cfg_idx_t CFG_INVERSE_CAPACITY = 3'd1;
	localparam cfg_idx_t CFG_SECRETION_RATE = 3'd2;
	localparam cfg_idx_t CFG_CONSUMPTION_RATE = 3'd3;
	localparam cfg_idx_t CFG_TIME_STEP = 3'd4;
	localparam cfg_idx_t CFG_INITIAL_POPULATION = 3'd5;
	localparam cfg_idx_t CFG_INITIAL_CONCENTRATION = 3'd6;

	localparam logic [31:0] GROWTH_RATE_RST = 32'd2197815;
	localparam logic [39:0] INVERSE_CAPACITY_RST = 40'd10995116;
	localparam logic [31:0] SECRETION_RATE_RST = 32'd671089;
	localparam logic [31:0] CONSUMPTION_RATE_RST = 32'd33554432;
	localparam logic [31:0] TIME_STEP_RST = 32'd838861;
	localparam logic [46:0] INITIAL_POPULATION_RST = 47'd327680000;
	localparam logic [46:0] INITIAL_CONCENTRATION_RST = 47'd0;

	typedef enum logic [3:0] {
		OP_MOV,
		OP_ADD,
		OP_SUB,
		OP_RSUB,
		OP_ADDPOS,
		OP_FIX,
		OP_LOAD,
		OP_MUL,
		OP_DIV6,
		OP_SNAP,
		OP_END
	} op_t;

	typedef enum logic [3:0] {
		SRC_REG,
		SRC_K,
		SRC_INVK,
		SRC_M,
		SRC_KX,
		SRC_DT,
		SRC_ONE,
		SRC_N0,
		SRC_X0
	} src_t;

	typedef enum logic [1:0] {
		SH_RATE,
		SH_HALF,
		SH_INV,
		SH_FRAC
	} shift_t;

	typedef logic [3:0] reg_idx_t;
	typedef logic [PC_W-1:0] pc_t;

	localparam reg_idx_t R_N = 4'd0;
	localparam reg_idx_t R_X = 4'd1;
	localparam reg_idx_t R_YN = 4'd2;
	localparam reg_idx_t R_YX = 4'd3;
	localparam reg_idx_t R_SN = 4'd4;
	localparam reg_idx_t R_SX = 4'd5;
	localparam reg_idx_t R_KN = 4'd6;
	localparam reg_idx_t R_KX = 4'd7;
	localparam reg_idx_t R_T0 = 4'd8;
	localparam reg_idx_t R_T1 = 4'd9;
	localparam reg_idx_t R_T2 = 4'd10;

	localparam pc_t PC_LOAD = 7'd0;
	localparam pc_t PC_SNAP = 7'd2;

	typedef struct packed {
		op_t op;
		reg_idx_t a;
		src_t bsrc;
		reg_idx_t b;
		reg_idx_t dst;
		shift_t sh;
	} uop_t;

	typedef struct packed {
		logic start;
		op_t op;
		shift_t sh;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic sat;
	} alu_rsp_t;

	typedef struct packed {
		logic restart;
	} tick_word_t;

	typedef struct packed {
		logic [OUT_W-1:0] population;
		logic [OUT_W-1:0] concentration;
		logic [INDEX_OUT_W-1:0] step_index;
		logic saturated;
	} sample_word_t;

	function automatic uop_t mk(op_t op, reg_idx_t a, src_t bsrc, reg_idx_t b, reg_idx_t dst,
		shift_t sh);
		uop_t u;
		u.op = op;
		u.a = a;
		u.bsrc = bsrc;
		u.b = b;
		u.dst = dst;
		u.sh = sh;
		return u;
	endfunction

	// The step program: reload, snapshot, four derivative passes, then the update.
	function automatic uop_t ucode(pc_t pc);
		uop_t prog [2**PC_W];
		int n;
		reg_idx_t yn;
		reg_idx_t yx;
		shift_t psh;
		for (int k = 0; k < 2**PC_W; k++) begin
			prog[k] = mk(OP_END, R_N, SRC_REG, R_X, R_T0, SH_RATE);
		end
		n = 0;
		prog[n] = mk(OP_LOAD, R_N, SRC_N0, R_N, R_N, SH_RATE); n++;
		prog[n] = mk(OP_LOAD, R_X, SRC_X0, R_X, R_X, SH_RATE); n++;
		prog[n] = mk(OP_SNAP, R_N, SRC_REG, R_X, R_T0, SH_RATE); n++;
		for (int s = 0; s < 4; s++) begin
			yn = (s == 0) ? R_N : R_YN;
			yx = (s == 0) ? R_X : R_YX;
			psh = (s == 3) ? SH_RATE : SH_HALF;
			if (s > 0) begin
				prog[n] = mk(OP_MUL, R_KN, SRC_DT, R_T0, R_T2, psh); n++;
				prog[n] = mk(OP_ADD, R_N, SRC_REG, R_T2, R_YN, SH_RATE); n++;
				prog[n] = mk(OP_MUL, R_KX, SRC_DT, R_T0, R_T2, psh); n++;
				prog[n] = mk(OP_ADD, R_X, SRC_REG, R_T2, R_YX, SH_RATE); n++;
			end
			prog[n] = mk(OP_MUL, yn, SRC_INVK, R_T0, R_T0, SH_INV); n++;
			prog[n] = mk(OP_RSUB, R_T0, SRC_ONE, R_T0, R_T0, SH_RATE); n++;
			prog[n] = mk(OP_MUL, yn, SRC_K, R_T0, R_T1, SH_RATE); n++;
			prog[n] = mk(OP_MUL, R_T1, SRC_REG, R_T0, R_T1, SH_FRAC); n++;
			prog[n] = mk(OP_FIX, R_T1, SRC_REG, yn, R_KN, SH_RATE); n++;
			prog[n] = mk(OP_MUL, yn, SRC_M, R_T0, R_T0, SH_RATE); n++;
			prog[n] = mk(OP_MUL, yx, SRC_KX, R_T0, R_T2, SH_RATE); n++;
			prog[n] = mk(OP_SUB, R_T0, SRC_REG, R_T2, R_T0, SH_RATE); n++;
			prog[n] = mk(OP_FIX, R_T0, SRC_REG, yx, R_KX, SH_RATE); n++;
			if (s == 0) begin
				prog[n] = mk(OP_MOV, R_KN, SRC_REG, R_T0, R_SN, SH_RATE); n++;
				prog[n] = mk(OP_MOV, R_KX, SRC_REG, R_T0, R_SX, SH_RATE); n++;
			end else if (s < 3) begin
				prog[n] = mk(OP_ADD, R_KN, SRC_REG, R_KN, R_T2, SH_RATE); n++;
				prog[n] = mk(OP_ADD, R_SN, SRC_REG, R_T2, R_SN, SH_RATE); n++;
				prog[n] = mk(OP_ADD, R_KX, SRC_REG, R_KX, R_T2, SH_RATE); n++;
				prog[n] = mk(OP_ADD, R_SX, SRC_REG, R_T2, R_SX, SH_RATE); n++;
			end else begin
				prog[n] = mk(OP_ADD, R_SN, SRC_REG, R_KN, R_SN, SH_RATE); n++;
				prog[n] = mk(OP_ADD, R_SX, SRC_REG, R_KX, R_SX, SH_RATE); n++;
			end
		end
		prog[n] = mk(OP_MUL, R_SN, SRC_DT, R_T0, R_T0, SH_RATE); n++;
		prog[n] = mk(OP_DIV6, R_T0, SRC_REG, R_T0, R_T0, SH_RATE); n++;
		prog[n] = mk(OP_ADDPOS, R_N, SRC_REG, R_T0, R_N, SH_RATE); n++;
		prog[n] = mk(OP_MUL, R_SX, SRC_DT, R_T0, R_T0, SH_RATE); n++;
		prog[n] = mk(OP_DIV6, R_T0, SRC_REG, R_T0, R_T0, SH_RATE); n++;
		prog[n] = mk(OP_ADDPOS, R_X, SRC_REG, R_T0, R_X, SH_RATE); n++;
		return prog[pc];
	endfunction

endpackage

@@ design/lsrk_stream_if.sv @@
interface lsrk_stream_if #(
	parameter type word_t = logic
);
	logic valid;
	logic ready;
	word_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ design/lsrk_regfile.sv @@
module lsrk_regfile
	import lsrk_pkg::*;
#(
	parameter int VALUE_WIDTH = 48
) (
	input  logic clk,
	input  logic we,
	input  reg_idx_t waddr,
	input  logic [VALUE_WIDTH-1:0] wdata,
	input  reg_idx_t raddr_a,
	input  reg_idx_t raddr_b,
	output logic [VALUE_WIDTH-1:0] rdata_a,
	output logic [VALUE_WIDTH-1:0] rdata_b
);

	logic [VALUE_WIDTH-1:0] mem [2**$bits(reg_idx_t)];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

@@ design/lsrk_alu.sv @@
module lsrk_alu
	import lsrk_pkg::*;
#(
	parameter int VALUE_WIDTH = 48,
	parameter int VALUE_FRAC_BITS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  alu_req_t req,
	input  logic [VALUE_WIDTH-1:0] a,
	input  logic [OPW-1:0] b,
	output alu_rsp_t rsp,
	output logic [VALUE_WIDTH-1:0] result
);

	localparam int VW = VALUE_WIDTH;
	localparam int PROD_W = 2 * MAG_W;
	localparam int RND_W = PROD_W + 1;
	localparam int DIV_STEPS = (VW + 1 + 7) / 8;
	localparam int DIV_BITS = DIV_STEPS * 8;
	localparam int CNT_W = $clog2(DIV_STEPS);
	localparam logic [VW-1:0] VMAX = {1'b0, {(VW - 1){1'b1}}};
	localparam logic [VW-1:0] VMIN = {1'b1, {(VW - 1){1'b0}}};

	typedef enum logic [2:0] {A_IDLE, A_MUL, A_RND, A_FIN, A_DIV} alu_state_t;

	alu_state_t state_q;
	op_t op_q;
	shift_t sh_q;
	logic done_q;
	logic sat_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [MAG_W-1:0] ma_q;
	logic [MAG_W-1:0] mb_q;
	logic [PROD_W-1:0] acc_q;
	logic [VW-1:0] mag_q;
	logic [VW-1:0] result_q;
	logic [DIV_BITS-1:0] div_q;
	logic [DIV_BITS-1:0] quo_q;
	logic [2:0] rem_q;

	logic [VW-1:0] b_v;
	logic [VW-1:0] a_abs;
	logic [OPW-1:0] b_abs;
	logic [VW:0] sum_add;
	logic [VW:0] sum_sub;
	logic [VW:0] sum_rsub;
	logic [VW:0] s_sel;
	logic s_ovf;
	logic [VW-1:0] s_val;
	logic [VW-1:0] simple_res;
	logic simple_sat;
	logic [31:0] a_part;
	logic [31:0] b_part;
	logic [63:0] pp;
	logic [PROD_W-1:0] pp_sh;
	logic [5:0] sh_amt;
	logic [RND_W-1:0] rounded;
	logic [RND_W-1:0] lim;
	logic [3:0] dt;
	logic [2:0] dr;
	logic [7:0] qb;
	logic [2:0] rem_next;
	logic [DIV_BITS-1:0] quo_next;
	logic [VW:0] div_in;

	always_comb begin
		b_v = b[VW-1:0];
		a_abs = a[VW-1] ? (~a + 1'b1) : a;
		b_abs = b[OPW-1] ? (~b + 1'b1) : b;
		div_in = {1'b0, a_abs} + (VW + 1)'(3);
		sum_add = {a[VW-1], a} + {b_v[VW-1], b_v};
		sum_sub = {a[VW-1], a} - {b_v[VW-1], b_v};
		sum_rsub = {b_v[VW-1], b_v} - {a[VW-1], a};
		case (req.op) inside
			OP_SUB: s_sel = sum_sub;
			OP_RSUB: s_sel = sum_rsub;
			default: s_sel = sum_add;
		endcase
		s_ovf = s_sel[VW] != s_sel[VW-1];
		s_val = s_ovf ? (s_sel[VW] ? VMIN : VMAX) : s_sel[VW-1:0];
		simple_res = a;
		simple_sat = 1'b0;
		case (req.op) inside
			OP_ADD, OP_SUB, OP_RSUB: begin
				simple_res = s_val;
				simple_sat = s_ovf;
			end
			OP_ADDPOS: begin
				simple_res = s_val[VW-1] ? '0 : s_val;
				simple_sat = s_ovf;
			end
			OP_FIX: begin
				simple_res = (a[VW-1] && (b_v[VW-1] || b_v == '0)) ? '0 : a;
			end
			OP_LOAD: begin
				if (b > OPW'(VMAX)) begin
					simple_res = VMAX;
					simple_sat = 1'b1;
				end else begin
					simple_res = b_v;
				end
			end
			default: simple_res = a;
		endcase
	end

	always_comb begin
		a_part = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		b_part = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = {32'b0, a_part} * {32'b0, b_part};
		case (cnt_q[1:0])
			2'd0: pp_sh = PROD_W'(pp);
			2'd3: pp_sh = PROD_W'(pp) << 64;
			default: pp_sh = PROD_W'(pp) << 32;
		endcase
		case (sh_q)
			SH_RATE: sh_amt = 6'd24;
			SH_HALF: sh_amt = 6'd25;
			SH_INV: sh_amt = 6'd40;
			default: sh_amt = 6'(VALUE_FRAC_BITS);
		endcase
		rounded = ({1'b0, acc_q} + (RND_W'(1) << (sh_amt - 6'd1))) >> sh_amt;
		lim = RND_W'(VMAX) + RND_W'(neg_q);
	end

	always_comb begin
		dr = rem_q;
		qb = '0;
		dt = '0;
		for (int i = 0; i < 8; i++) begin
			dt = {dr, div_q[DIV_BITS-1-i]};
			if (dt >= 4'd6) begin
				qb[7-i] = 1'b1;
				dr = 3'(dt - 4'd6);
			end else begin
				dr = dt[2:0];
			end
		end
		rem_next = dr;
		quo_next = {quo_q[DIV_BITS-9:0], qb};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_IDLE;
			op_q <= OP_MOV;
			sh_q <= SH_RATE;
			done_q <= 1'b0;
			sat_q <= 1'b0;
			neg_q <= 1'b0;
			cnt_q <= '0;
			ma_q <= '0;
			mb_q <= '0;
			acc_q <= '0;
			mag_q <= '0;
			result_q <= '0;
			div_q <= '0;
			quo_q <= '0;
			rem_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				A_IDLE: begin
					if (req.start) begin
						op_q <= req.op;
						sh_q <= req.sh;
						sat_q <= 1'b0;
						cnt_q <= '0;
						if (req.op == OP_MUL) begin
							ma_q <= MAG_W'(a_abs);
							mb_q <= b_abs[MAG_W-1:0];
							neg_q <= a[VW-1] ^ b[OPW-1];
							acc_q <= '0;
							state_q <= A_MUL;
						end else if (req.op == OP_DIV6) begin
							div_q <= DIV_BITS'(div_in);
							quo_q <= '0;
							rem_q <= '0;
							neg_q <= a[VW-1];
							state_q <= A_DIV;
						end else begin
							result_q <= simple_res;
							sat_q <= simple_sat;
							done_q <= 1'b1;
						end
					end
				end
				A_MUL: begin
					acc_q <= acc_q + pp_sh;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q[1:0] == 2'd3) begin
						state_q <= A_RND;
					end
				end
				A_RND: begin
					if (rounded > lim) begin
						mag_q <= lim[VW-1:0];
						sat_q <= 1'b1;
					end else begin
						mag_q <= rounded[VW-1:0];
					end
					state_q <= A_FIN;
				end
				A_DIV: begin
					div_q <= div_q << 8;
					quo_q <= quo_next;
					rem_q <= rem_next;
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						mag_q <= quo_next[VW-1:0];
						state_q <= A_FIN;
					end
				end
				A_FIN: begin
					result_q <= neg_q ? (~mag_q + 1'b1) : mag_q;
					done_q <= 1'b1;
					state_q <= A_IDLE;
				end
				default: state_q <= A_IDLE;
			endcase
		end
	end

	assign rsp.done = done_q;
	assign rsp.sat = sat_q;
	assign result = result_q;

`ifndef NO_ASSERTIONS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("alu done held for more than one cycle");
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> state_q == A_IDLE)
		else $error("alu started while busy");
	a_addpos_nonneg: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && op_q == OP_ADDPOS |-> !result_q[VW-1])
		else $error("clamped state update is negative");
`endif

endmodule

@@ design/logistic_secretion_rk4_step_top.sv @@
// Fixed-point fourth-order Runge-Kutta stepper for a logistic population and
// a secreted product. Each word on the tick channel advances both states by
// one step; a set restart bit first reloads the initial values from the
// configuration registers and clears the step counter.
// Each tick yields exactly one word on the sample channel, holding the states
// and the step count as they were before the step, and a flag that is set if
// any arithmetic of the step saturated.
// All arithmetic runs through one shared unit under a microcoded sequencer:
// a 32x32 multiplier taken over four partial products, a saturating adder and
// a divide-by-six that resolves eight quotient bits a cycle.
// Once the sample word is loaded the sequencer returns to idle, and the next
// tick can be accepted in the cycle after. Every instruction has a fetch and
// an issue state; a multiply then sums its partial products, rounds and ends,
// a divide by six resolves its quotient and ends, the rest answer directly.
// A finished sample waits in an output register and a new tick may be taken
// meanwhile; if that step ends before the receiver takes the old word, the
// sequencer holds at its last instruction and takes no tick. Reset returns the
// configuration registers to their defaults and clears the states and the step
// counter. Configuration must be written while the block is idle (unenforced).
module logistic_secretion_rk4_step_top
	import lsrk_pkg::*;
#(
	parameter int VALUE_WIDTH = 48,
	parameter int VALUE_FRAC_BITS = 16,
	parameter int STEP_COUNT_WIDTH = 32
) (
	input  logic clk,
	input  logic arst_n,
	lsrk_stream_if.sink tick,
	lsrk_stream_if.source sample,
	input  logic cfg_we,
	input  cfg_idx_t cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int VW = VALUE_WIDTH;
	localparam logic [VW-1:0] ONE_VAL = (VALUE_FRAC_BITS >= VALUE_WIDTH - 1) ?
		{1'b0, {(VW - 1){1'b1}}} : ({{(VW - 1){1'b0}}, 1'b1} << VALUE_FRAC_BITS);

	typedef enum logic [1:0] {S_IDLE, S_FETCH, S_EXEC, S_WAIT} seq_state_t;

	seq_state_t state_q;
	pc_t pc_q;
	logic [31:0] growth_q;
	logic [39:0] invk_q;
	logic [31:0] secr_q;
	logic [31:0] cons_q;
	logic [31:0] dt_q;
	logic [46:0] pop0_q;
	logic [46:0] conc0_q;
	logic [VW-1:0] n_q;
	logic [VW-1:0] x_q;
	logic [STEP_COUNT_WIDTH-1:0] step_q;
	logic sat_acc_q;
	logic [VW-1:0] snap_pop_q;
	logic [VW-1:0] snap_conc_q;
	logic out_valid_q;
	sample_word_t out_q;

	uop_t uop;
	logic [VW-1:0] rd_a;
	logic [VW-1:0] rd_b;
	logic [VW-1:0] a_val;
	logic [VW-1:0] b_reg_val;
	logic [OPW-1:0] b_op;
	alu_req_t alu_req;
	alu_rsp_t alu_rsp;
	logic [VW-1:0] alu_res;
	logic rf_we;
	logic out_free;
	logic out_load;

	assign uop = ucode(pc_q);
	assign out_free = !out_valid_q || sample.ready;
	assign out_load = (state_q == S_EXEC) && (uop.op == OP_END) && out_free;

	always_comb begin
		a_val = (uop.a == R_N) ? n_q : ((uop.a == R_X) ? x_q : rd_a);
		b_reg_val = (uop.b == R_N) ? n_q : ((uop.b == R_X) ? x_q : rd_b);
		unique case (uop.bsrc)
			SRC_REG: b_op = {{(OPW - VW){b_reg_val[VW-1]}}, b_reg_val};
			SRC_K: b_op = OPW'(growth_q);
			SRC_INVK: b_op = OPW'(invk_q);
			SRC_M: b_op = OPW'(secr_q);
			SRC_KX: b_op = OPW'(cons_q);
			SRC_DT: b_op = OPW'(dt_q);
			SRC_ONE: b_op = OPW'(ONE_VAL);
			SRC_N0: b_op = OPW'(pop0_q);
			SRC_X0: b_op = OPW'(conc0_q);
			default: b_op = '0;
		endcase
		alu_req.start = (state_q == S_EXEC) && (uop.op != OP_SNAP) && (uop.op != OP_END);
		alu_req.op = uop.op;
		alu_req.sh = uop.sh;
		rf_we = (state_q == S_WAIT) && alu_rsp.done && (uop.dst != R_N) && (uop.dst != R_X);
	end

	lsrk_regfile #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_regfile (
		.clk(clk),
		.we(rf_we),
		.waddr(uop.dst),
		.wdata(alu_res),
		.raddr_a(uop.a),
		.raddr_b(uop.b),
		.rdata_a(rd_a),
		.rdata_b(rd_b)
	);

	lsrk_alu #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.VALUE_FRAC_BITS(VALUE_FRAC_BITS)
	) u_alu (
		.clk(clk),
		.arst_n(arst_n),
		.req(alu_req),
		.a(a_val),
		.b(b_op),
		.rsp(alu_rsp),
		.result(alu_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= PC_SNAP;
			growth_q <= GROWTH_RATE_RST;
			invk_q <= INVERSE_CAPACITY_RST;
			secr_q <= SECRETION_RATE_RST;
			cons_q <= CONSUMPTION_RATE_RST;
			dt_q <= TIME_STEP_RST;
			pop0_q <= INITIAL_POPULATION_RST;
			conc0_q <= INITIAL_CONCENTRATION_RST;
			n_q <= '0;
			x_q <= '0;
			step_q <= '0;
			sat_acc_q <= 1'b0;
			snap_pop_q <= '0;
			snap_conc_q <= '0;
			out_valid_q <= 1'b0;
			out_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_GROWTH_RATE: growth_q <= cfg_data[31:0];
					CFG_INVERSE_CAPACITY: invk_q <= cfg_data[39:0];
					CFG_SECRETION_RATE: secr_q <= cfg_data[31:0];
					CFG_CONSUMPTION_RATE: cons_q <= cfg_data[31:0];
					CFG_TIME_STEP: dt_q <= cfg_data[31:0];
					CFG_INITIAL_POPULATION: pop0_q <= cfg_data;
					CFG_INITIAL_CONCENTRATION: conc0_q <= cfg_data;
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (sample.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (tick.valid) begin
						sat_acc_q <= 1'b0;
						if (tick.data.restart) begin
							pc_q <= PC_LOAD;
							step_q <= '0;
						end else begin
							pc_q <= PC_SNAP;
						end
						state_q <= S_FETCH;
					end
				end
				S_FETCH: state_q <= S_EXEC;
				S_EXEC: begin
					if (uop.op == OP_SNAP) begin
						snap_pop_q <= a_val;
						snap_conc_q <= b_reg_val;
						pc_q <= pc_q + 1'b1;
						state_q <= S_FETCH;
					end else if (uop.op == OP_END) begin
						if (out_free) begin
							out_q.population <= OUT_W'(snap_pop_q);
							out_q.concentration <= OUT_W'(snap_conc_q);
							out_q.step_index <= INDEX_OUT_W'(step_q);
							out_q.saturated <= sat_acc_q;
							step_q <= step_q + 1'b1;
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_WAIT;
					end
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						sat_acc_q <= sat_acc_q | alu_rsp.sat;
						if (uop.dst == R_N) begin
							n_q <= alu_res;
						end
						if (uop.dst == R_X) begin
							x_q <= alu_res;
						end
						pc_q <= pc_q + 1'b1;
						state_q <= S_FETCH;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign tick.ready = (state_q == S_IDLE);
	assign sample.valid = out_valid_q;
	assign sample.data = out_q;

endmodule
